// ----- src/pwo_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwo_pkg: shared types and constants for the wavetable oscillator
// Request codes, sequencer states, fixed field widths and parameter defaults.
// ----------------------------------------------------------------------------
package pwo_pkg;

  // fixed field widths
  localparam int REQ_W    = 2;
  localparam int VIDX_IN_W = 3;
  localparam int PHASE_W  = 15;
  localparam int MDIV_W   = 4;
  localparam int TIDX_W   = 8;
  localparam int TSAMP_W  = 12;
  localparam int MIX_W    = 15;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  localparam logic [PHASE_W-1:0] PHASE_MOD = 15'h7FFF;
  localparam logic [MIX_W-1:0]   MIX_MAX   = 15'h7FFF;

  // parameter defaults
  localparam int VOICES_DEF      = 8;
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int PHASE_SHIFT_DEF = 7;
  localparam int SAMPLE_BITS_DEF = 12;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_STEP  = 2'd1,
    REQ_DIV   = 2'd2,
    REQ_TABLE = 2'd3
  } pwo_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PHASE,
    S_MOD,
    S_RED,
    S_ACC,
    S_MIX,
    S_QUO,
    S_DONE
  } pwo_state_t;

endpackage

// ----- src/polyphonic_wavetable_oscillator.sv -----
`timescale 1ns / 1ps
// A set-step, set-divisor or table-write request is taken in S_IDLE. A sample tick
// visits S_PHASE and S_ACC for each active voice and only S_PHASE for a silent voice,
// then S_MIX, the shared divider in S_QUO (skipped for a zero divisor) and S_DONE to
// load the result. A table depth that is not a power of two adds S_MOD and S_RED
// per active voice for the index modulo. in_tready is low for the whole tick.
// Reset (rst_n low) clears the state, voice index, output valid, divisor, phases and steps.
// ----------------------------------------------------------------------------
// polyphonic_wavetable_oscillator: multi-voice wavetable mixer
// Sequencer walks voices one at a time through a shared table and divider.
// ----------------------------------------------------------------------------
module polyphonic_wavetable_oscillator #(
  parameter int VOICES      = pwo_pkg::VOICES_DEF,
  parameter int TABLE_DEPTH = pwo_pkg::TABLE_DEPTH_DEF,
  parameter int PHASE_SHIFT = pwo_pkg::PHASE_SHIFT_DEF,
  parameter int SAMPLE_BITS = pwo_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // voice_index[2:0], note_increment[17:3], divisor_value[21:18],
  // table_index[29:22], table_sample[41:30]
  input  logic [pwo_pkg::IN_DATA_W-1:0]    in_tdata,
  // req_type[1:0]
  input  logic [pwo_pkg::REQ_W-1:0]        in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // mixed_sample[14:0]
  output logic [pwo_pkg::OUT_DATA_W-1:0]   out_tdata,
  // zero_divisor[0]
  output logic [0:0]                       out_tuser
);

  import pwo_pkg::*;

  localparam int  VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int  ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int  SUM_W   = SAMPLE_BITS + $clog2(VOICES + 1);
  localparam int  DVS_W   = MDIV_W;
  localparam int  DVD_W   = (SUM_W > PHASE_W) ? SUM_W : PHASE_W;
  localparam bit  IS_POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);

  // reciprocal for the table-depth modulo, exact over any 15-bit index
  localparam int  RCP_L   = $clog2(TABLE_DEPTH);
  localparam int  RCP_S   = PHASE_W + RCP_L;
  localparam int  RCP_W   = PHASE_W + 2;
  localparam int  PROD_W  = PHASE_W + RCP_W;
  localparam logic [RCP_W-1:0]   RCP_M   =
    RCP_W'(((64'd1 << RCP_S) / TABLE_DEPTH) + 1);
  localparam logic [PHASE_W-1:0] DEPTH_C = PHASE_W'(TABLE_DEPTH);

  // input fields
  logic [VIDX_IN_W-1:0] f_vidx;
  logic [PHASE_W-1:0]   f_step;
  logic [MDIV_W-1:0]    f_div;
  logic [TIDX_W-1:0]    f_tidx;
  logic [TSAMP_W-1:0]   f_samp;
  pwo_req_t             f_req;

  assign f_vidx = in_tdata[2:0];
  assign f_step = in_tdata[17:3];
  assign f_div  = in_tdata[21:18];
  assign f_tidx = in_tdata[29:22];
  assign f_samp = in_tdata[41:30];
  assign f_req  = pwo_req_t'(in_tuser);

  pwo_state_t         state_r, state_nxt;
  logic [VIDX_W-1:0]  v_r, v_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [PHASE_W-1:0] phase_r [VOICES];
  logic [PHASE_W-1:0] step_r  [VOICES];
  logic [MDIV_W-1:0]  mdiv_r;
  logic [MIX_W-1:0]   res_sample_r, res_sample_nxt;
  logic               res_flag_r, res_flag_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [MIX_W-1:0]   out_sample_r, out_sample_nxt;
  logic               out_flag_r, out_flag_nxt;
  logic [PHASE_W-1:0] mod_q_r, mod_q_nxt;

  logic [SAMPLE_BITS-1:0] wave_mem [TABLE_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data_r;
  logic [ADDR_W-1:0]      rd_addr;

  logic               accept;
  logic               last_voice;
  logic [PHASE_W-1:0] cur_phase, cur_step, new_phase, tbl_idx;
  logic [PHASE_W:0]   phase_sum;
  logic               phase_we;
  logic               step_we, mdiv_we, tbl_we;
  logic [PHASE_W-1:0] cur_idx, mod_rem;
  logic [PROD_W-1:0]  rcp_prod;

  logic               div_start, div_busy, div_done;
  logic [DVD_W-1:0]   div_dvd, div_quo;
  logic [DVS_W-1:0]   div_dvs;

  assign accept     = in_tvalid && in_tready;
  assign last_voice = (v_r == VIDX_W'(VOICES - 1));
  assign cur_phase  = phase_r[v_r];
  assign cur_step   = step_r[v_r];

  // phase advance, wrapping at 0x7FFF; a zero step clears the phase
  always_comb begin
    phase_sum = {1'b0, cur_phase} + {1'b0, cur_step};
    if (cur_step == '0) begin
      new_phase = '0;
    end else if (phase_sum < {1'b0, PHASE_MOD}) begin
      new_phase = phase_sum[PHASE_W-1:0];
    end else begin
      new_phase = PHASE_W'(phase_sum - {1'b0, PHASE_MOD});
    end
    tbl_idx = new_phase >> PHASE_SHIFT;
  end

  // index modulo: quotient by reciprocal in S_MOD, remainder in S_RED
  assign cur_idx  = cur_phase >> PHASE_SHIFT;
  assign rcp_prod = PROD_W'(cur_idx) * PROD_W'(RCP_M);
  assign mod_rem  = cur_idx - PHASE_W'(mod_q_r * DEPTH_C);

  assign rd_addr = (state_r == S_RED) ? ADDR_W'(mod_rem) : ADDR_W'(tbl_idx);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && f_req == REQ_TICK) state_nxt = S_PHASE;
      end
      S_PHASE: begin
        if (cur_step == '0) begin
          state_nxt = last_voice ? S_MIX : S_PHASE;
        end else begin
          state_nxt = IS_POW2 ? S_ACC : S_MOD;
        end
      end
      S_MOD: begin
        state_nxt = S_RED;
      end
      S_RED: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        state_nxt = last_voice ? S_MIX : S_PHASE;
      end
      S_MIX: begin
        state_nxt = (mdiv_r == '0) ? S_DONE : S_QUO;
      end
      S_QUO: begin
        if (div_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and handshake outputs
  always_comb begin
    in_tready      = (state_r == S_IDLE);
    v_nxt          = v_r;
    sum_nxt        = sum_r;
    res_sample_nxt = res_sample_r;
    res_flag_nxt   = res_flag_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_flag_nxt   = out_flag_r;
    mod_q_nxt      = mod_q_r;
    phase_we       = 1'b0;
    step_we        = 1'b0;
    mdiv_we        = 1'b0;
    tbl_we         = 1'b0;
    div_start      = 1'b0;
    div_dvd        = DVD_W'(sum_r);
    div_dvs        = mdiv_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (f_req)
            REQ_TICK: begin
              v_nxt   = '0;
              sum_nxt = '0;
            end
            REQ_STEP:  step_we = (int'(f_vidx) < VOICES);
            REQ_DIV:   mdiv_we = 1'b1;
            REQ_TABLE: tbl_we  = (int'(f_tidx) < TABLE_DEPTH);
            default: ;
          endcase
        end
      end
      S_PHASE: begin
        phase_we = 1'b1;
        if (cur_step == '0) begin
          if (!last_voice) v_nxt = v_r + 1'b1;
        end
      end
      S_MOD: begin
        mod_q_nxt = PHASE_W'(rcp_prod >> RCP_S);
      end
      S_ACC: begin
        sum_nxt = sum_r + SUM_W'(rd_data_r);
        if (!last_voice) v_nxt = v_r + 1'b1;
      end
      S_MIX: begin
        if (mdiv_r == '0) begin
          res_sample_nxt = '0;
          res_flag_nxt   = 1'b1;
        end else begin
          div_start = 1'b1;
        end
      end
      S_QUO: begin
        if (div_done) begin
          res_sample_nxt = (div_quo > DVD_W'(MIX_MAX)) ? MIX_MAX : div_quo[MIX_W-1:0];
          res_flag_nxt   = 1'b0;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = res_sample_r;
          out_flag_nxt   = res_flag_r;
        end
      end
      default: ;
    endcase
  end

  pwo_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mdiv_r      <= '0;
      v_r         <= '0;
      for (int i = 0; i < VOICES; i++) begin
        phase_r[i] <= '0;
        step_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      v_r         <= v_nxt;
      if (mdiv_we) mdiv_r <= f_div;
      if (step_we) step_r[VIDX_W'(f_vidx)] <= f_step;
      if (phase_we) phase_r[v_r] <= new_phase;
    end
    sum_r        <= sum_nxt;
    res_sample_r <= res_sample_nxt;
    res_flag_r   <= res_flag_nxt;
    out_sample_r <= out_sample_nxt;
    out_flag_r   <= out_flag_nxt;
    mod_q_r      <= mod_q_nxt;
  end

  // wavetable, registered read
  always_ff @(posedge clk) begin
    if (tbl_we) wave_mem[ADDR_W'(f_tidx)] <= SAMPLE_BITS'(f_samp);
    rd_data_r <= wave_mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_sample_r);
  assign out_tuser  = out_flag_r;

  a_zero_div_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[MIX_W-1:0] == '0)
    else $error("zero-divisor result carries a nonzero sample");

  a_div_not_restarted: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_tick_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    accept && f_req == REQ_TICK |=> state_r == S_PHASE && v_r == '0 && sum_r == '0)
    else $error("tick did not start the voice walk at voice zero");

  a_acc_active_voice: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACC |-> cur_step != '0)
    else $error("silent voice accumulated");

endmodule

// ----- src/pwo_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwo_div: shared restoring divider
// One quotient bit per cycle; the quotient holds after done.
// ----------------------------------------------------------------------------
module pwo_div #(
  parameter int DVD_W = 16,
  parameter int DVS_W = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             fits;

  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    fits    = (shifted >= {1'b0, dvs_r});

    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;

endmodule
